>>> rtl/cfb_pkg.sv
package cfb_pkg;

    localparam int OP_W     = 2;
    localparam int ITEM_W   = 32;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int CAP_W    = 9;
    localparam int OUT_W    = 56;

    localparam logic [OP_W-1:0] OP_ADD       = 2'd0;
    localparam logic [OP_W-1:0] OP_OVERWRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ      = 2'd2;
    localparam logic [OP_W-1:0] OP_RESET_RD  = 2'd3;

    typedef struct packed {
        logic               accepted;
        logic               pop;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] count_after;
        logic               is_empty;
        logic               is_full;
    } res_t;

endpackage

>>> rtl/cfb_ctrl.sv
module cfb_ctrl #(
    parameter int DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cfb_pkg::CAP_W-1:0]   cfg_data,
    input  logic                        req_fire,
    input  logic [cfb_pkg::OP_W-1:0]    op,
    output logic                        wr_en,
    output logic [$clog2((DEPTH < 511) ? DEPTH : 511)-1:0] wr_addr,
    output logic                        rd_en,
    output logic [$clog2((DEPTH < 511) ? DEPTH : 511)-1:0] rd_addr,
    output cfb_pkg::res_t               res
);
    import cfb_pkg::*;

    localparam int CAPMAX = (DEPTH < 511) ? DEPTH : 511;
    localparam int PW     = $clog2(CAPMAX);
    localparam logic [16:0] DEPTH_W = 17'(DEPTH);

    logic [CAP_W-1:0]   capacity_reg;
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [COUNT_W-1:0] cap;
    logic               full;
    logic [PW-1:0]      wr_inc;
    logic [PW-1:0]      rd_inc;
    logic [9:0]         wr_sum;
    logic [9:0]         rd_sum;
    logic [9:0]         rewind;
    logic [9:0]         rewind_wrap;
    logic [PW-1:0]      rewind_ptr;
    logic [PW-1:0]      slot;
    logic [15:0]        slot_wide;

    always_comb
    begin
        if (capacity_reg == '0)
            cap = COUNT_W'(1);
        else if ({8'd0, capacity_reg} > DEPTH_W)
            cap = COUNT_W'(DEPTH);
        else
            cap = capacity_reg;
    end

    assign full   = (count_reg >= cap);
    assign wr_sum = 10'(wr_ptr_reg) + 10'd1;
    assign rd_sum = 10'(rd_ptr_reg) + 10'd1;
    assign wr_inc = (wr_sum >= 10'(cap)) ? '0 : PW'(wr_sum);
    assign rd_inc = (rd_sum >= 10'(cap)) ? '0 : PW'(rd_sum);

    assign rewind      = 10'(wr_ptr_reg) + 10'(cap) - 10'(count_reg);
    assign rewind_wrap = (rewind >= 10'(cap)) ? (rewind - 10'(cap)) : rewind;
    assign rewind_ptr  = PW'(rewind_wrap);

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        res.accepted = 1'b1;
        res.pop      = 1'b0;
        slot         = wr_ptr_reg;
        case (op)
            OP_ADD:
            begin
                if (full)
                    res.accepted = 1'b0;
                else
                begin
                    wr_en       = 1'b1;
                    wr_ptr_next = wr_inc;
                    count_next  = count_reg + COUNT_W'(1);
                end
            end
            OP_OVERWRITE:
            begin
                wr_en       = 1'b1;
                wr_ptr_next = wr_inc;
                if (full)
                    rd_ptr_next = rd_inc;
                else
                    count_next = count_reg + COUNT_W'(1);
            end
            OP_READ:
            begin
                slot = rd_ptr_reg;
                if (count_reg == '0)
                    res.accepted = 1'b0;
                else
                begin
                    rd_en       = 1'b1;
                    res.pop     = 1'b1;
                    rd_ptr_next = rd_inc;
                    count_next  = count_reg - COUNT_W'(1);
                end
            end
            default:
            begin
                rd_ptr_next = rewind_ptr;
                slot        = rewind_ptr;
            end
        endcase
        wr_en           = wr_en & req_fire;
        rd_en           = rd_en & req_fire;
        slot_wide       = 16'(slot);
        res.slot_index  = slot_wide[SLOT_W-1:0];
        res.count_after = count_next;
        res.is_empty    = (count_next == '0);
        res.is_full     = (count_next == cap);
    end

    assign wr_addr         = wr_ptr_reg;
    assign rd_addr         = rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(256);
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_data;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else if (req_fire)
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/cfb_mem.sv
module cfb_mem #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2((DEPTH < 511) ? DEPTH : 511)-1:0] wr_addr,
    input  logic [cfb_pkg::ITEM_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [$clog2((DEPTH < 511) ? DEPTH : 511)-1:0] rd_addr,
    output logic [cfb_pkg::ITEM_W-1:0]  rd_data
);
    import cfb_pkg::*;

    localparam int CAPMAX = (DEPTH < 511) ? DEPTH : 511;
    localparam int SW     = (DATA_WIDTH < ITEM_W) ? DATA_WIDTH : ITEM_W;

    logic [SW-1:0] store [CAPMAX];
    logic [SW-1:0] rd_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_addr] <= wr_data[SW-1:0];
        if (rd_en)
            rd_q_reg <= store[rd_addr];
    end

    assign rd_data = ITEM_W'(rd_q_reg);

endmodule

>>> rtl/cfb_out.sv
module cfb_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  cfb_pkg::res_t               res,
    input  logic [cfb_pkg::ITEM_W-1:0]  mem_data,
    output logic                        in_ready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cfb_pkg::OUT_W-1:0]   m_tdata
);
    import cfb_pkg::*;

    logic              main_valid_reg;
    res_t              main_res_reg;
    logic              skid_valid_reg;
    res_t              skid_res_reg;
    logic [ITEM_W-1:0] skid_data_reg;

    logic [ITEM_W-1:0] main_data;
    logic              m_fire;
    res_t              sel_res;
    logic [ITEM_W-1:0] sel_data;

    assign main_data = main_res_reg.pop ? mem_data : '0;
    assign m_fire    = m_tvalid & m_tready;
    assign in_ready  = !skid_valid_reg;
    assign m_tvalid  = skid_valid_reg | main_valid_reg;
    assign sel_res   = skid_valid_reg ? skid_res_reg : main_res_reg;
    assign sel_data  = skid_valid_reg ? skid_data_reg : main_data;

    assign m_tdata = {4'd0, sel_res.is_full, sel_res.is_empty, sel_res.count_after,
                      sel_res.slot_index, sel_data, sel_res.accepted};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_fire)
                skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (load && main_valid_reg && !m_fire)
                skid_valid_reg <= 1'b1;
            if (load)
                main_valid_reg <= 1'b1;
            else if (m_fire)
                main_valid_reg <= 1'b0;
        end
    end

    // park the stalled result before the new one lands
    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && load && main_valid_reg && !m_fire)
        begin
            skid_res_reg  <= main_res_reg;
            skid_data_reg <= main_data;
        end
        if (load)
            main_res_reg <= res;
    end

endmodule

>>> rtl/circular_fifo_buffer_top.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    s_tuser: op; s_tdata: item_data
// m_*       out        m_tvalid/m_tready    m_tdata: result fields
// cfg_*     in         cfg_valid/cfg_ready  cfg_data: capacity
//
// One request per cycle while s_tready is high; its result is registered.
// Pointer and count update in one pass; the slot read comes from a
// registered memory port. A two-deep output (result plus skid) keeps
// s_tready high for one stalled result; a second stalled result drops it.
// Reset clears pointers and count and sets capacity to 256; slot contents
// stay undefined until written. cfg_ready is always high.
module circular_fifo_buffer_top #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cfb_pkg::OP_W-1:0]     s_tuser,   // [1:0] op
    input  logic [cfb_pkg::ITEM_W-1:0]   s_tdata,   // [31:0] item_data
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] accepted, [32:1] read_data, [40:33] slot_index, [49:41] count_after,
    // [50] is_empty, [51] is_full, [55:52] zero
    output logic [cfb_pkg::OUT_W-1:0]    m_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cfb_pkg::CAP_W-1:0]    cfg_data   // [8:0] capacity
);
    import cfb_pkg::*;

    localparam int CAPMAX = (DEPTH < 511) ? DEPTH : 511;
    localparam int PW     = $clog2(CAPMAX);

    logic              req_fire;
    logic              cfg_we;
    logic              wr_en;
    logic              rd_en;
    logic [PW-1:0]     wr_addr;
    logic [PW-1:0]     rd_addr;
    logic [ITEM_W-1:0] mem_data;
    res_t              res;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;
    assign req_fire  = s_tvalid & s_tready;

    cfb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req_fire (req_fire),
        .op       (s_tuser),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .res      (res)
    );

    cfb_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mem_data)
    );

    cfb_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (req_fire),
        .res      (res),
        .mem_data (mem_data),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> tb/sv/tb_circular_fifo_buffer_top.sv
module tb_circular_fifo_buffer_top;

    import cfb_pkg::*;

    localparam int STORE_DEPTH    = 256;
    localparam int PHASE_ITEMS    = 215;
    localparam int CYCLE_LIMIT    = 250000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic               accepted;
        logic [ITEM_W-1:0]  read_data;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] count_after;
        logic               is_empty;
        logic               is_full;
    } fifo_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [OP_W-1:0]    s_tuser = OP_ADD;
    logic [ITEM_W-1:0]  s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b1;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data = '0;

    logic [ITEM_W-1:0]  ring_mem [STORE_DEPTH];
    int                 wr_ptr;
    int                 rd_ptr;
    int                 held_items;
    logic [CAP_W-1:0]   cap_setting;

    fifo_result_t       expected_results [$];
    int                 error_count;
    int                 cycle_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    circular_fifo_buffer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int active_capacity();
        int c;
        c = int'(cap_setting);
        if (c == 0)
        begin
            c = 1;
        end
        if (c > STORE_DEPTH)
        begin
            c = STORE_DEPTH;
        end
        return c;
    endfunction

    function automatic int advance_slot(int p, int cap);
        return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    function automatic fifo_result_t apply_request(logic [OP_W-1:0] op, logic [ITEM_W-1:0] item);
        fifo_result_t res;
        int           cap;
        int           cnt;
        int           r;
        logic         full;
        cap = active_capacity();
        full = (held_items >= cap);
        res = '0;
        res.accepted = 1'b1;
        case (op)
            OP_ADD:
            begin
                res.slot_index = SLOT_W'(wr_ptr);
                if (full)
                begin
                    res.accepted = 1'b0;
                end
                else
                begin
                    ring_mem[wr_ptr] = item;
                    wr_ptr = advance_slot(wr_ptr, cap);
                    held_items++;
                end
            end
            OP_OVERWRITE:
            begin
                res.slot_index = SLOT_W'(wr_ptr);
                ring_mem[wr_ptr] = item;
                wr_ptr = advance_slot(wr_ptr, cap);
                if (full)
                begin
                    rd_ptr = advance_slot(rd_ptr, cap);
                end
                else
                begin
                    held_items++;
                end
            end
            OP_READ:
            begin
                res.slot_index = SLOT_W'(rd_ptr);
                if (held_items == 0)
                begin
                    res.accepted = 1'b0;
                end
                else
                begin
                    res.read_data = ring_mem[rd_ptr];
                    rd_ptr = advance_slot(rd_ptr, cap);
                    held_items--;
                end
            end
            default:
            begin
                cnt = (held_items > cap) ? cap : held_items;
                r = wr_ptr + cap - cnt;
                while (r >= cap)
                begin
                    r -= cap;
                end
                rd_ptr = r;
                res.slot_index = SLOT_W'(r);
            end
        endcase
        res.count_after = COUNT_W'(held_items);
        res.is_empty = (held_items == 0);
        res.is_full = (held_items == cap);
        return res;
    endfunction

    task automatic compare_field(string name, logic [ITEM_W-1:0] want, logic [ITEM_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
            begin
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin
        fifo_result_t want;
        if (s_tvalid && s_tready)
        begin
            expected_results.push_back(apply_request(s_tuser, s_tdata));
        end
        if (cfg_valid && cfg_ready)
        begin
            cap_setting = cfg_data;
            wr_ptr = 0;
            rd_ptr = 0;
            held_items = 0;
        end
        if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("unexpected result %h", m_tdata);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("accepted", ITEM_W'(want.accepted), ITEM_W'(m_tdata[0]));
                compare_field("read_data", want.read_data, m_tdata[32:1]);
                compare_field("slot_index", ITEM_W'(want.slot_index),
                              ITEM_W'(m_tdata[40:33]));
                compare_field("count_after", ITEM_W'(want.count_after),
                              ITEM_W'(m_tdata[49:41]));
                compare_field("is_empty", ITEM_W'(want.is_empty), ITEM_W'(m_tdata[50]));
                compare_field("is_full", ITEM_W'(want.is_full), ITEM_W'(m_tdata[51]));
                compare_field("padding", '0, ITEM_W'(m_tdata[55:52]));
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic set_idle_mode(int mode);
        case (mode % 4)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 45;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 45;
            end
            default:
            begin
                send_idle_pct = 12;
                recv_stall_pct = 12;
            end
        endcase
    endtask

    task automatic send_request(logic [OP_W-1:0] op, logic [ITEM_W-1:0] item);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= item;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        drain_and_settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_empty_and_extremes();
        set_idle_mode(0);
        send_request(OP_READ, 32'h1111_1111);
        send_request(OP_RESET_RD, 32'h0);
        send_request(OP_ADD, 32'h0000_0000);
        send_request(OP_ADD, 32'hFFFF_FFFF);
        send_request(OP_OVERWRITE, 32'hAAAA_AAAA);
        send_request(OP_ADD, 32'h5555_5555);
        send_request(OP_RESET_RD, 32'hFFFF_FFFF);
        repeat (4) send_request(OP_READ, 32'hFFFF_FFFF);
        send_request(OP_READ, 32'h0);
        drain_and_settle();
    endtask

    task automatic test_single_slot();
        set_idle_mode(3);
        write_capacity(9'd1);
        send_request(OP_ADD, 32'h1234_5678);
        send_request(OP_ADD, 32'h8765_4321);
        send_request(OP_OVERWRITE, 32'hDEAD_BEEF);
        send_request(OP_RESET_RD, 32'h0);
        send_request(OP_READ, 32'h0);
        send_request(OP_READ, 32'h0);
        drain_and_settle();
    endtask

    task automatic test_capacity_bounds();
        set_idle_mode(2);
        write_capacity(9'd0);
        send_request(OP_ADD, 32'hCAFE_0001);
        send_request(OP_ADD, 32'hCAFE_0002);
        send_request(OP_READ, 32'h0);
        write_capacity(9'h1FF);
        send_request(OP_ADD, 32'h0BAD_F00D);
        send_request(OP_READ, 32'h0);
        write_capacity(9'd3);
        repeat (3) send_request(OP_ADD, $urandom);
        send_request(OP_OVERWRITE, 32'h0000_0003);
        send_request(OP_RESET_RD, 32'h0);
        repeat (3) send_request(OP_READ, 32'h0);
        drain_and_settle();
    endtask

    function automatic logic [OP_W-1:0] pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:
            begin
                if (r < 60) return OP_ADD;
                if (r < 85) return OP_OVERWRITE;
                if (r < 96) return OP_READ;
                return OP_RESET_RD;
            end
            1:
            begin
                if (r < 75) return OP_READ;
                if (r < 85) return OP_ADD;
                if (r < 90) return OP_OVERWRITE;
                return OP_RESET_RD;
            end
            default:
            begin
                return r[1:0];
            end
        endcase
    endfunction

    function automatic logic [ITEM_W-1:0] pick_item();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    task automatic test_random_traffic();
        logic [CAP_W-1:0] cap_plan [8];
        int               sent;
        int               run_len;
        int               mode;
        cap_plan = '{9'd256, 9'd5, 9'd1, 9'h1FF, 9'd2, 9'd17, 9'd0, 9'd64};
        cap_plan[6] = $urandom_range(1, 511);
        for (int phase = 0; phase < 8; phase++)
        begin
            set_idle_mode(phase);
            write_capacity(cap_plan[phase]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                mode = $urandom_range(0, 2);
                run_len = $urandom_range(1, active_capacity() + 4);
                for (int j = 0; j < run_len && sent < PHASE_ITEMS; j++)
                begin
                    send_request(pick_op(mode), pick_item());
                    sent++;
                end
            end
            drain_and_settle();
        end
    endtask

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            ring_mem[i] = '0;
        end
        wr_ptr = 0;
        rd_ptr = 0;
        held_items = 0;
        cap_setting = 9'd256;
        error_count = 0;
        cycle_count = 0;
        set_idle_mode(0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_extremes();
        test_single_slot();
        test_capacity_bounds();
        test_random_traffic();

        drain_and_settle();
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/cfb_pkg.sv
rtl/cfb_ctrl.sv
rtl/cfb_mem.sv
rtl/cfb_out.sv
rtl/circular_fifo_buffer_top.sv
tb/sv/tb_circular_fifo_buffer_top.sv
